@@ src/failure_count_blocklist_macros.svh @@
// Assertion macros shared by the blocklist checker.
// Needs signals clock and reset in the scope where the macros are used.
`ifndef FAILURE_COUNT_BLOCKLIST_MACROS_SVH
`define FAILURE_COUNT_BLOCKLIST_MACROS_SVH

// implication in the same cycle, outside reset
`define FCB_ASSERT_NOW(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("blocklist check failed");

// implication in the next cycle, outside reset
`define FCB_ASSERT_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("blocklist check failed");

// implication in the next cycle, checked through reset as well
`define FCB_ASSERT_ALWAYS(lbl, a, c) \
   lbl: assert property (@(posedge clock) (a) |=> (c)) \
      else $error("blocklist check failed");

`endif

@@ src/fbl_pkg.sv @@
// Package for the failure-count blocklist: table sizes, beat types, entry type.
// No dependencies.
`default_nettype none
package fbl_pkg;

   localparam int BAN_SLOTS   = 64;
   localparam int WATCH_SLOTS = 64;
   localparam int SLOT_MAX    = (BAN_SLOTS > WATCH_SLOTS) ? BAN_SLOTS : WATCH_SLOTS;
   localparam int POS_W       = $clog2(SLOT_MAX);

   localparam logic [2:0] KIND_FAIL  = 3'd0;
   localparam logic [2:0] KIND_QUERY = 3'd1;
   localparam logic [2:0] KIND_BAN   = 3'd2;
   localparam logic [2:0] KIND_UNBAN = 3'd3;
   localparam logic [2:0] KIND_SWEEP = 3'd4;

   localparam logic [1:0] REG_ENABLED  = 2'd0;
   localparam logic [1:0] REG_MAX      = 2'd1;
   localparam logic [1:0] REG_BAN_SEC  = 2'd2;
   localparam logic [1:0] REG_COOL_SEC = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] address;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic       took_effect;
      logic [7:0] fail_count;
      logic       table_full;
   } rsp_type;

   // one table slot; the ban table uses stamp as expiry and ignores count
   typedef struct packed {
      logic        valid;
      logic [31:0] address;
      logic [7:0]  count;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic        enabled;
      logic [7:0]  max_tries;
      logic [31:0] ban_seconds;
      logic [31:0] cooldown_seconds;
   } cfg_type;

   typedef struct packed {
      logic      ban_shift;
      logic      watch_shift;
      entry_type ban_wb;
      entry_type watch_wb;
   } ring_ctl_type;

endpackage
`default_nettype wire

@@ src/fbl_cell.sv @@
// One slot of a rotating table ring; takes its neighbour's entry on shift.
// Depends on fbl_pkg.
`default_nettype none
module fbl_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  shift,
   input  fbl_pkg::entry_type   d,
   output fbl_pkg::entry_type   q
);
   import fbl_pkg::*;

   logic        valid_ff;
   logic [31:0] address_ff;
   logic [7:0]  count_ff;
   logic [31:0] stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         address_ff <= d.address;
         count_ff   <= d.count;
         stamp_ff   <= d.stamp;
      end
   end

   assign q = '{valid: valid_ff, address: address_ff, count: count_ff, stamp: stamp_ff};
endmodule
`default_nettype wire

@@ src/fbl_ctrl.sv @@
// Sequencer: scans both rings for one lap, decides, then rewrites on a second lap.
// Depends on fbl_pkg.
`default_nettype none
module fbl_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  fbl_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output fbl_pkg::rsp_type       rsp_data,
   input  fbl_pkg::cfg_type       cfg,
   input  fbl_pkg::entry_type     ban_head,
   input  fbl_pkg::entry_type     watch_head,
   output fbl_pkg::ring_ctl_type  ring
);
   import fbl_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_APPLY  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   localparam logic [POS_W:0]   BAN_LIM   = (POS_W+1)'(BAN_SLOTS);
   localparam logic [POS_W:0]   WATCH_LIM = (POS_W+1)'(WATCH_SLOTS);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(SLOT_MAX - 1);
   localparam logic [POS_W-1:0] BAN_LAST  = POS_W'(BAN_SLOTS - 1);
   localparam logic [POS_W-1:0] WATCH_LAST = POS_W'(WATCH_SLOTS - 1);

   state_type state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   req_type item_ff;
   logic [POS_W-1:0] sw_all_ff, sw_ban_ff, sw_watch_ff;

   logic wfound_ff, wfree_ok_ff, bfound_ff, bfree_ok_ff;
   logic [POS_W-1:0] widx_ff, wfree_ff, bidx_ff, bfree_ff;
   logic [7:0] wcnt_ff;

   logic bwr_ff, wwr_ff, took_ff, full_ff, banned_ff;
   logic [POS_W-1:0] btgt_ff, wtgt_ff;
   entry_type bnew_ff, wnew_ff;
   logic [7:0] cnt_ff;

   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic in_ban, in_watch, scanning, applying;

   // decision terms
   logic d_bwr, d_wwr, d_took, d_full, d_banned;
   logic [POS_W-1:0] d_btgt, d_wtgt;
   entry_type d_bnew, d_wnew;
   logic [7:0] d_cnt, next_cnt;
   logic [32:0] exp_sum;
   logic [31:0] expiry;
   logic want_ban, wact;

   logic sweep_ban_hit, sweep_watch_due;
   logic [32:0] due_sum;

   assign scanning = (state_ff == ST_SCAN);
   assign applying = (state_ff == ST_APPLY);
   assign in_ban   = {1'b0, pos_ff} < BAN_LIM;
   assign in_watch = {1'b0, pos_ff} < WATCH_LIM;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
            pos_in = '0;
         end
         ST_SCAN: begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == POS_LAST) begin
               state_in = ST_DECIDE;
               pos_in   = '0;
            end
         end
         ST_DECIDE: state_in = ST_APPLY;
         ST_APPLY: begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == POS_LAST) begin
               state_in = ST_FINISH;
               pos_in   = '0;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) item_ff <= req_data;
   end

   // first lap: note matches and lowest free slots as they pass the head
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         wfound_ff   <= 1'b0;
         wfree_ok_ff <= 1'b0;
         bfound_ff   <= 1'b0;
         bfree_ok_ff <= 1'b0;
      end else if (scanning) begin
         if (in_watch) begin
            if (watch_head.valid && watch_head.address == item_ff.address && !wfound_ff) begin
               wfound_ff <= 1'b1;
               widx_ff   <= pos_ff;
               wcnt_ff   <= watch_head.count;
            end
            if (!watch_head.valid && !wfree_ok_ff) begin
               wfree_ok_ff <= 1'b1;
               wfree_ff    <= pos_ff;
            end
         end
         if (in_ban) begin
            if (ban_head.valid && ban_head.address == item_ff.address && !bfound_ff) begin
               bfound_ff <= 1'b1;
               bidx_ff   <= pos_ff;
            end
            if (!ban_head.valid && !bfree_ok_ff) begin
               bfree_ok_ff <= 1'b1;
               bfree_ff    <= pos_ff;
            end
         end
      end
   end

   always_comb begin
      exp_sum  = {1'b0, item_ff.now_seconds} + {1'b0, cfg.ban_seconds};
      expiry   = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
      next_cnt = wfound_ff ? ((wcnt_ff == 8'hFF) ? 8'hFF : wcnt_ff + 8'd1) : 8'd1;
      d_bwr    = 1'b0;
      d_wwr    = 1'b0;
      d_took   = 1'b0;
      d_full   = 1'b0;
      d_cnt    = 8'd0;
      d_btgt   = bfree_ff;
      d_wtgt   = wfound_ff ? widx_ff : wfree_ff;
      d_bnew   = '{valid: 1'b1, address: item_ff.address, count: 8'd0, stamp: expiry};
      d_wnew   = '{valid: 1'b1, address: item_ff.address, count: next_cnt,
                   stamp: item_ff.now_seconds};
      want_ban = 1'b0;
      wact     = 1'b0;
      case (item_ff.kind)
         KIND_FAIL: begin
            if (cfg.enabled) begin
               wact = wfound_ff || wfree_ok_ff;
               if (!wact) d_full = 1'b1;
               else begin
                  d_wwr = 1'b1;
                  d_cnt = next_cnt;
                  if (next_cnt >= cfg.max_tries) begin
                     d_wnew.valid = 1'b0;
                     want_ban     = 1'b1;
                  end
               end
            end
         end
         KIND_BAN: want_ban = 1'b1;
         KIND_UNBAN: begin
            d_btgt       = bidx_ff;
            d_bnew.valid = 1'b0;
            d_bwr        = bfound_ff;
            d_took       = bfound_ff;
         end
         default: ;
      endcase
      if (want_ban && !bfound_ff) begin
         if (bfree_ok_ff) begin
            d_bwr  = 1'b1;
            d_took = 1'b1;
         end else begin
            d_full = 1'b1;
         end
      end
      d_banned = (item_ff.kind == KIND_UNBAN) ? 1'b0 : (bfound_ff || (want_ban && d_bwr));
   end

   // second lap: write back the head, changed where this item touches it
   always_comb begin
      due_sum         = {1'b0, watch_head.stamp} + {1'b0, cfg.cooldown_seconds};
      sweep_ban_hit   = applying && item_ff.kind == KIND_SWEEP && pos_ff == sw_ban_ff
                        && ban_head.valid && ban_head.stamp <= item_ff.now_seconds;
      sweep_watch_due = applying && item_ff.kind == KIND_SWEEP && pos_ff == sw_watch_ff
                        && watch_head.valid && due_sum <= {1'b0, item_ff.now_seconds};
      ring.ban_shift   = (scanning || applying) && in_ban;
      ring.watch_shift = (scanning || applying) && in_watch;
      ring.ban_wb      = ban_head;
      ring.watch_wb    = watch_head;
      if (applying && bwr_ff && pos_ff == btgt_ff) ring.ban_wb = bnew_ff;
      if (sweep_ban_hit) ring.ban_wb.valid = 1'b0;
      if (applying && wwr_ff && pos_ff == wtgt_ff) ring.watch_wb = wnew_ff;
      if (sweep_watch_due) begin
         if (watch_head.count > 8'd1) begin
            ring.watch_wb.count = watch_head.count - 8'd1;
            ring.watch_wb.stamp = item_ff.now_seconds;
         end else begin
            ring.watch_wb.valid = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         bwr_ff    <= d_bwr;
         wwr_ff    <= d_wwr;
         btgt_ff   <= d_btgt;
         wtgt_ff   <= d_wtgt;
         bnew_ff   <= d_bnew;
         wnew_ff   <= d_wnew;
         took_ff   <= d_took;
         full_ff   <= d_full;
         cnt_ff    <= d_cnt;
         banned_ff <= d_banned;
      end else if (sweep_ban_hit || (sweep_watch_due && watch_head.count <= 8'd1)) begin
         took_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_all_ff   <= '0;
         sw_ban_ff   <= '0;
         sw_watch_ff <= '0;
      end else if (applying && pos_ff == POS_LAST && item_ff.kind == KIND_SWEEP) begin
         if (sw_all_ff == POS_LAST) begin
            sw_all_ff   <= '0;
            sw_ban_ff   <= '0;
            sw_watch_ff <= '0;
         end else begin
            sw_all_ff   <= sw_all_ff + 1'b1;
            sw_ban_ff   <= (sw_ban_ff == BAN_LAST) ? '0 : sw_ban_ff + 1'b1;
            sw_watch_ff <= (sw_watch_ff == WATCH_LAST) ? '0 : sw_watch_ff + 1'b1;
         end
      end
   end

   // result register: the next item may start while this beat waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.allowed     <= (item_ff.kind == KIND_SWEEP) || !cfg.enabled || !banned_ff;
         rsp_ff.took_effect <= took_ff;
         rsp_ff.fail_count  <= cnt_ff;
         rsp_ff.table_full  <= full_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

@@ src/failure_count_blocklist.sv @@
// Failure-count blocklist: one item at a time, from request beat to result by a
// scan lap and a rewrite lap of both rings, with a decide step between them.
// A new request is taken while a finished result waits. Synchronous reset
// empties both tables, zeroes the sweep index and loads register defaults.
`default_nettype none
module failure_count_blocklist (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  fbl_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output fbl_pkg::rsp_type   rsp_data,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire [3:0]          paddr,
   input  wire [31:0]         pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import fbl_pkg::*;

   cfg_type      cfg_ff;
   ring_ctl_type ring;
   entry_type    ban_q   [BAN_SLOTS];
   entry_type    watch_q [WATCH_SLOTS];
   logic         wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled          <= 1'b1;
         cfg_ff.max_tries        <= 8'd5;
         cfg_ff.ban_seconds      <= 32'd3600;
         cfg_ff.cooldown_seconds <= 32'd600;
      end else if (wr) begin
         case (paddr[3:2])
            REG_ENABLED:  cfg_ff.enabled          <= pwdata[0];
            REG_MAX:      cfg_ff.max_tries        <= pwdata[7:0];
            REG_BAN_SEC:  cfg_ff.ban_seconds      <= pwdata;
            REG_COOL_SEC: cfg_ff.cooldown_seconds <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_ENABLED:  prdata = {31'd0, cfg_ff.enabled};
         REG_MAX:      prdata = {24'd0, cfg_ff.max_tries};
         REG_BAN_SEC:  prdata = cfg_ff.ban_seconds;
         REG_COOL_SEC: prdata = cfg_ff.cooldown_seconds;
         default:      prdata = 32'd0;
      endcase
   end

   // rings rotate towards slot 0; the head re-enters at the tail
   for (genvar i = 0; i < BAN_SLOTS; i++) begin : g_ban
      if (i == BAN_SLOTS - 1) begin : g_tail
         fbl_cell u_cell (.clock, .reset, .shift(ring.ban_shift), .d(ring.ban_wb),
                          .q(ban_q[i]));
      end else begin : g_mid
         fbl_cell u_cell (.clock, .reset, .shift(ring.ban_shift), .d(ban_q[i+1]),
                          .q(ban_q[i]));
      end
   end

   for (genvar i = 0; i < WATCH_SLOTS; i++) begin : g_watch
      if (i == WATCH_SLOTS - 1) begin : g_tail
         fbl_cell u_cell (.clock, .reset, .shift(ring.watch_shift), .d(ring.watch_wb),
                          .q(watch_q[i]));
      end else begin : g_mid
         fbl_cell u_cell (.clock, .reset, .shift(ring.watch_shift), .d(watch_q[i+1]),
                          .q(watch_q[i]));
      end
   end

   fbl_ctrl u_ctrl (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .cfg(cfg_ff),
      .ban_head(ban_q[0]),
      .watch_head(watch_q[0]),
      .ring
   );
endmodule
`default_nettype wire

@@ src/fbl_checker.sv @@
// Port-level checks for the blocklist, bound to the top level.
// Depends on fbl_pkg and failure_count_blocklist_macros.svh.
`default_nettype none
`include "failure_count_blocklist_macros.svh"
module fbl_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input fbl_pkg::rsp_type  rsp_data,
   input wire               pready
);
   import fbl_pkg::*;

   `FCB_ASSERT_ALWAYS(a_reset_idle, reset, req_ready && !rsp_valid)
   `FCB_ASSERT_NEXT(a_busy_after_beat, req_valid && req_ready, !req_ready)
   `FCB_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `FCB_ASSERT_NOW(a_pready, 1'b1, pready)
endmodule

bind failure_count_blocklist fbl_checker u_fbl_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data, .pready
);
`default_nettype wire
